// ===== hdl/atcw_pkg.sv =====
`timescale 1ns / 1ps

package atcw_pkg;

   // Sizes of the grid and the escape parser.
   localparam int MAX_CSI_PARAMS = 5;
   localparam int MAX_COLUMNS    = 256;
   localparam int MAX_ROWS       = 128;
   // Tab stops sit every TAB_WIDTH columns; a power of two.
   localparam int TAB_WIDTH      = 4;

   localparam int CNT_W     = $clog2(MAX_CSI_PARAMS + 1);
   localparam int IDX_W     = (MAX_CSI_PARAMS > 1) ? $clog2(MAX_CSI_PARAMS) : 1;
   localparam int P2_IDX    = (MAX_CSI_PARAMS > 1) ? 1 : 0;
   localparam int COLS_W    = $clog2(MAX_COLUMNS + 1);
   localparam int ROWS_W    = $clog2(MAX_ROWS + 1);
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int TAB_BITS  = $clog2(TAB_WIDTH);
   localparam int TAB_CNT_W = $clog2(TAB_WIDTH + 1);

   // Fixed field widths of the ports.
   localparam int BYTE_W     = 8;
   localparam int COLOR_W    = 24;
   localparam int PARAM_W    = 16;
   localparam int CELL_ROW_W = 7;
   localparam int CELL_COL_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;
   localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;
   localparam logic [PARAM_W-1:0] PARAM_MAX   = 16'hFFFF;

   localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_BS     = 8'h08;
   localparam logic [BYTE_W-1:0] CHAR_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_ESC    = 8'h1B;
   localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_0      = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_9      = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_SEMI   = 8'h3B;
   localparam logic [BYTE_W-1:0] CHAR_LBRACK = 8'h5B;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_H = 8'h48;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_J = 8'h4A;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_M = 8'h6D;

   localparam logic [COLOR_W-1:0] NORMAL_PALETTE [8] = '{
      24'h000000, 24'hAA0000, 24'h00AA00, 24'hAA5500,
      24'h0000AA, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA
   };
   localparam logic [COLOR_W-1:0] BRIGHT_PALETTE [8] = '{
      24'h555555, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
      24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_COLUMNS     = 2'd0,
      CSR_GRID_ROWS        = 2'd1,
      CSR_BACKGROUND_COLOR = 2'd2,
      CSR_CONSOLE_ENABLE   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESC    = 2'd1,
      MODE_CSI    = 2'd2
   } parse_mode_type;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_SCROLL = 2'd1,
      OP_CLEAR  = 2'd2
   } op_kind_type;

   typedef enum logic [3:0] {
      BC_NUL,
      BC_ESC,
      BC_LBRACKET,
      BC_DIGIT,
      BC_SEMI,
      BC_BS,
      BC_CR,
      BC_LF,
      BC_TAB,
      BC_LOWER_M,
      BC_UPPER_J,
      BC_UPPER_H,
      BC_OTHER
   } byte_class_type;

   typedef enum logic [4:0] {
      DP_NONE,
      DP_LOAD,
      DP_ENTER_ESC,
      DP_CANCEL_ESC,
      DP_CSI_START,
      DP_DIGIT,
      DP_SEMI,
      DP_CSI_OTHER,
      DP_SGR_START,
      DP_SGR_STEP,
      DP_ERASE,
      DP_CUP,
      DP_BS,
      DP_CR,
      DP_LF,
      DP_TAB_START,
      DP_PUT_START,
      DP_WRAP,
      DP_WRITE
   } dp_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SGR,
      ST_WRAP,
      ST_WRITE
   } ctrl_state_type;

   typedef struct packed {
      parse_mode_type mode;
      byte_class_type cls;
      logic           enable;
      logic           count_zero;
      logic           count_one;
      logic           tab_last;
      logic           out_free;
   } dp_status_type;

   // Apply one SGR code to the current foreground; unknown codes keep it.
   function automatic logic [COLOR_W-1:0] sgr_color(input logic [PARAM_W-1:0] code,
                                                    input logic [COLOR_W-1:0] cur);
      logic [COLOR_W-1:0] result;
      result = cur;
      if (code == '0) begin
         result = COLOR_WHITE;
      end else if (code inside {[16'd30:16'd37]}) begin
         result = NORMAL_PALETTE[3'(code - 16'd30)];
      end else if (code inside {[16'd90:16'd97]}) begin
         result = BRIGHT_PALETTE[3'(code - 16'd90)];
      end
      return result;
   endfunction

endpackage

// ===== hdl/atcw_ctrl.sv =====
`timescale 1ns / 1ps

module atcw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  atcw_pkg::dp_status_type status,
   output atcw_pkg::dp_op_type     dp_op
);

   atcw_pkg::ctrl_state_type state_ff;
   atcw_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= atcw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dp_op     = atcw_pkg::DP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         atcw_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dp_op    = atcw_pkg::DP_LOAD;
               state_in = atcw_pkg::ST_DECODE;
            end
         end
         atcw_pkg::ST_DECODE: begin
            // Steps that may emit wait for a free output register.
            if (!status.enable || status.cls == atcw_pkg::BC_NUL) begin
               state_in = atcw_pkg::ST_IDLE;
            end else begin
               case (status.mode)
                  atcw_pkg::MODE_CSI: begin
                     state_in = atcw_pkg::ST_IDLE;
                     case (status.cls)
                        atcw_pkg::BC_DIGIT: dp_op = atcw_pkg::DP_DIGIT;
                        atcw_pkg::BC_SEMI:  dp_op = atcw_pkg::DP_SEMI;
                        atcw_pkg::BC_LOWER_M: begin
                           dp_op = atcw_pkg::DP_SGR_START;
                           if (!status.count_zero) begin
                              state_in = atcw_pkg::ST_SGR;
                           end
                        end
                        atcw_pkg::BC_UPPER_J: begin
                           if (status.out_free) begin
                              dp_op = atcw_pkg::DP_ERASE;
                           end else begin
                              state_in = atcw_pkg::ST_DECODE;
                           end
                        end
                        atcw_pkg::BC_UPPER_H: dp_op = atcw_pkg::DP_CUP;
                        default:              dp_op = atcw_pkg::DP_CSI_OTHER;
                     endcase
                  end
                  atcw_pkg::MODE_ESC: begin
                     state_in = atcw_pkg::ST_IDLE;
                     if (status.cls == atcw_pkg::BC_LBRACKET) begin
                        dp_op = atcw_pkg::DP_CSI_START;
                     end else begin
                        dp_op = atcw_pkg::DP_CANCEL_ESC;
                     end
                  end
                  default: begin
                     state_in = atcw_pkg::ST_IDLE;
                     case (status.cls)
                        atcw_pkg::BC_ESC: dp_op = atcw_pkg::DP_ENTER_ESC;
                        atcw_pkg::BC_CR:  dp_op = atcw_pkg::DP_CR;
                        atcw_pkg::BC_BS, atcw_pkg::BC_LF: begin
                           if (!status.out_free) begin
                              state_in = atcw_pkg::ST_DECODE;
                           end else if (status.cls == atcw_pkg::BC_BS) begin
                              dp_op = atcw_pkg::DP_BS;
                           end else begin
                              dp_op = atcw_pkg::DP_LF;
                           end
                        end
                        atcw_pkg::BC_TAB: begin
                           dp_op    = atcw_pkg::DP_TAB_START;
                           state_in = atcw_pkg::ST_WRAP;
                        end
                        default: begin
                           dp_op    = atcw_pkg::DP_PUT_START;
                           state_in = atcw_pkg::ST_WRAP;
                        end
                     endcase
                  end
               endcase
            end
         end
         atcw_pkg::ST_SGR: begin
            dp_op = atcw_pkg::DP_SGR_STEP;
            if (status.count_one) begin
               state_in = atcw_pkg::ST_IDLE;
            end
         end
         atcw_pkg::ST_WRAP: begin
            if (status.out_free) begin
               dp_op    = atcw_pkg::DP_WRAP;
               state_in = atcw_pkg::ST_WRITE;
            end
         end
         atcw_pkg::ST_WRITE: begin
            if (status.out_free) begin
               dp_op = atcw_pkg::DP_WRITE;
               if (status.tab_last) begin
                  state_in = atcw_pkg::ST_IDLE;
               end else begin
                  state_in = atcw_pkg::ST_WRAP;
               end
            end
         end
         default: state_in = atcw_pkg::ST_IDLE;
      endcase
   end

`ifndef ASSERT_OFF
   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == atcw_pkg::ST_DECODE)
      else $error("accepted beat not followed by decode");
`endif

endmodule

// ===== hdl/atcw_datapath.sv =====
`timescale 1ns / 1ps

module atcw_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [atcw_pkg::BYTE_W-1:0]         req_byte_in,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [atcw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [atcw_pkg::CSR_DATA_W-1:0]     csr_data,
   input  atcw_pkg::dp_op_type                 dp_op,
   output atcw_pkg::dp_status_type             status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_op_kind,
   output logic [atcw_pkg::CELL_ROW_W-1:0]     rsp_cell_row,
   output logic [atcw_pkg::CELL_COL_W-1:0]     rsp_cell_column,
   output logic [atcw_pkg::BYTE_W-1:0]         rsp_cell_char,
   output logic [atcw_pkg::COLOR_W-1:0]        rsp_paint_color,
   output logic                                rsp_last_of_run
);

   localparam int CNT_W  = atcw_pkg::CNT_W;
   localparam int IDX_W  = atcw_pkg::IDX_W;
   localparam int COLS_W = atcw_pkg::COLS_W;
   localparam int ROWS_W = atcw_pkg::ROWS_W;
   localparam int ROW_W  = atcw_pkg::ROW_W;
   localparam int TCW    = atcw_pkg::TAB_CNT_W;
   localparam int PW     = atcw_pkg::PARAM_W;
   localparam int NP     = atcw_pkg::MAX_CSI_PARAMS;

   // Parser, cursor and grid setup.
   logic [atcw_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   atcw_pkg::parse_mode_type     mode_ff, mode_in;
   logic [PW-1:0]                params_ff [NP];
   logic [PW-1:0]                params_in [NP];
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [COLS_W-1:0]            col_ff, col_in;
   logic [ROW_W-1:0]             row_ff, row_in;
   logic [atcw_pkg::COLOR_W-1:0] fg_ff, fg_in;
   logic [COLS_W-1:0]            cols_ff, cols_in;
   logic [ROWS_W-1:0]            rows_ff, rows_in;
   logic [atcw_pkg::COLOR_W-1:0] bg_ff, bg_in;
   logic                         enable_ff, enable_in;
   logic [TCW-1:0]               tab_left_ff, tab_left_in;
   logic [atcw_pkg::BYTE_W-1:0]  put_char_ff, put_char_in;

   // Output register.
   logic                            out_valid_ff, out_valid_in;
   atcw_pkg::op_kind_type           out_kind_ff, out_kind_in;
   logic [atcw_pkg::CELL_ROW_W-1:0] out_row_ff, out_row_in;
   logic [atcw_pkg::CELL_COL_W-1:0] out_col_ff, out_col_in;
   logic [atcw_pkg::BYTE_W-1:0]     out_char_ff, out_char_in;
   logic [atcw_pkg::COLOR_W-1:0]    out_color_ff, out_color_in;
   logic                            out_last_ff, out_last_in;

   // Helpers.
   atcw_pkg::byte_class_type     cls;
   logic                         out_free;
   logic                         at_bottom;
   logic                         wrap_needed;
   logic [CNT_W-1:0]             c1;
   logic [IDX_W-1:0]             acc_idx;
   logic [3:0]                   digit;
   logic [PW+3:0]                acc;
   logic [PW-1:0]                acc_sat;
   logic [PW-1:0]                p1, p2, row_t, col_t;
   logic [ROW_W-1:0]             bottom_row;
   logic [COLS_W-1:0]            cols_new;
   logic [ROWS_W-1:0]            rows_new;

   logic                         emit;
   atcw_pkg::op_kind_type        emit_kind;
   logic [ROW_W-1:0]             emit_row;
   logic [COLS_W-1:0]            emit_col;
   logic [atcw_pkg::BYTE_W-1:0]  emit_char;
   logic [atcw_pkg::COLOR_W-1:0] emit_color;
   logic                         emit_last;

   assign csr_ready = 1'b1;

   always_comb begin
      if (byte_ff inside {[atcw_pkg::CHAR_0:atcw_pkg::CHAR_9]}) begin
         cls = atcw_pkg::BC_DIGIT;
      end else begin
         case (byte_ff)
            atcw_pkg::CHAR_NUL:     cls = atcw_pkg::BC_NUL;
            atcw_pkg::CHAR_ESC:     cls = atcw_pkg::BC_ESC;
            atcw_pkg::CHAR_LBRACK:  cls = atcw_pkg::BC_LBRACKET;
            atcw_pkg::CHAR_SEMI:    cls = atcw_pkg::BC_SEMI;
            atcw_pkg::CHAR_BS:      cls = atcw_pkg::BC_BS;
            atcw_pkg::CHAR_CR:      cls = atcw_pkg::BC_CR;
            atcw_pkg::CHAR_LF:      cls = atcw_pkg::BC_LF;
            atcw_pkg::CHAR_TAB:     cls = atcw_pkg::BC_TAB;
            atcw_pkg::CHAR_LOWER_M: cls = atcw_pkg::BC_LOWER_M;
            atcw_pkg::CHAR_UPPER_J: cls = atcw_pkg::BC_UPPER_J;
            atcw_pkg::CHAR_UPPER_H: cls = atcw_pkg::BC_UPPER_H;
            default:                cls = atcw_pkg::BC_OTHER;
         endcase
      end
   end

   assign out_free    = !out_valid_ff || !rsp_stall;
   assign at_bottom   = (ROWS_W'(row_ff) + ROWS_W'(1)) >= rows_ff;
   assign wrap_needed = col_ff >= cols_ff;
   assign bottom_row  = ROW_W'(rows_ff - ROWS_W'(1));

   assign status.mode       = mode_ff;
   assign status.cls        = cls;
   assign status.enable     = enable_ff;
   assign status.count_zero = count_ff == '0;
   assign status.count_one  = count_ff == CNT_W'(1);
   assign status.tab_last   = tab_left_ff == TCW'(1);
   assign status.out_free   = out_free;

   // Digit accumulation into the newest parameter, saturating.
   assign c1      = (count_ff == '0) ? CNT_W'(1) : count_ff;
   assign acc_idx = IDX_W'(c1 - CNT_W'(1));
   assign digit   = 4'(byte_ff - atcw_pkg::CHAR_0);
   assign acc     = ((PW+4)'(params_ff[acc_idx]) << 3) + ((PW+4)'(params_ff[acc_idx]) << 1)
                    + (PW+4)'(digit);
   assign acc_sat = (acc > (PW+4)'(atcw_pkg::PARAM_MAX)) ? atcw_pkg::PARAM_MAX : acc[PW-1:0];

   // First two parameters with their defaults of one.
   assign p1    = (count_ff != '0) ? params_ff[0] : PW'(1);
   assign p2    = (count_ff > CNT_W'(1)) ? params_ff[atcw_pkg::P2_IDX] : PW'(1);
   assign row_t = (p1 == '0) ? '0 : p1 - PW'(1);
   assign col_t = (p2 == '0) ? '0 : p2 - PW'(1);

   always_comb begin
      byte_in      = byte_ff;
      mode_in      = mode_ff;
      params_in    = params_ff;
      count_in     = count_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      fg_in        = fg_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      bg_in        = bg_ff;
      enable_in    = enable_ff;
      tab_left_in  = tab_left_ff;
      put_char_in  = put_char_ff;
      cols_new     = cols_ff;
      rows_new     = rows_ff;

      emit       = 1'b0;
      emit_kind  = atcw_pkg::OP_WRITE;
      emit_row   = '0;
      emit_col   = '0;
      emit_char  = atcw_pkg::CHAR_SPACE;
      emit_color = atcw_pkg::COLOR_BLACK;
      emit_last  = 1'b0;

      case (dp_op)
         atcw_pkg::DP_NONE: ;
         atcw_pkg::DP_LOAD:       byte_in = req_byte_in;
         atcw_pkg::DP_ENTER_ESC:  mode_in = atcw_pkg::MODE_ESC;
         atcw_pkg::DP_CANCEL_ESC: mode_in = atcw_pkg::MODE_NORMAL;
         atcw_pkg::DP_CSI_START: begin
            mode_in      = atcw_pkg::MODE_CSI;
            count_in     = '0;
            params_in[0] = '0;
         end
         atcw_pkg::DP_DIGIT: begin
            count_in           = c1;
            params_in[acc_idx] = acc_sat;
         end
         atcw_pkg::DP_SEMI: begin
            // Open a new zero parameter while the list has room.
            if (c1 < CNT_W'(NP)) begin
               count_in                  = c1 + CNT_W'(1);
               params_in[IDX_W'(c1)]     = '0;
            end else begin
               count_in = c1;
            end
         end
         atcw_pkg::DP_CSI_OTHER: mode_in = atcw_pkg::MODE_NORMAL;
         atcw_pkg::DP_SGR_START: begin
            mode_in = atcw_pkg::MODE_NORMAL;
            if (count_ff == '0) begin
               fg_in = atcw_pkg::COLOR_WHITE;
            end
         end
         atcw_pkg::DP_SGR_STEP: begin
            // Apply the oldest code and shift the list down.
            fg_in = atcw_pkg::sgr_color(params_ff[0], fg_ff);
            for (int k = 0; k < NP - 1; k++) begin
               params_in[k] = params_ff[k+1];
            end
            count_in = count_ff - CNT_W'(1);
         end
         atcw_pkg::DP_ERASE: begin
            mode_in = atcw_pkg::MODE_NORMAL;
            if (p1 == PW'(2)) begin
               col_in    = '0;
               row_in    = '0;
               emit      = 1'b1;
               emit_kind = atcw_pkg::OP_CLEAR;
               emit_last = 1'b1;
            end
         end
         atcw_pkg::DP_CUP: begin
            mode_in = atcw_pkg::MODE_NORMAL;
            row_in  = (row_t >= PW'(rows_ff)) ? bottom_row : ROW_W'(row_t);
            col_in  = (col_t >= PW'(cols_ff)) ? cols_ff - COLS_W'(1) : COLS_W'(col_t);
         end
         atcw_pkg::DP_BS: begin
            if (col_ff != '0) begin
               col_in     = col_ff - COLS_W'(1);
               emit       = 1'b1;
               emit_row   = row_ff;
               emit_col   = col_ff - COLS_W'(1);
               emit_color = fg_ff;
               emit_last  = 1'b1;
            end else if (row_ff != '0) begin
               row_in     = row_ff - ROW_W'(1);
               col_in     = cols_ff - COLS_W'(1);
               emit       = 1'b1;
               emit_row   = row_ff - ROW_W'(1);
               emit_col   = cols_ff - COLS_W'(1);
               emit_color = fg_ff;
               emit_last  = 1'b1;
            end
         end
         atcw_pkg::DP_CR: col_in = '0;
         atcw_pkg::DP_LF, atcw_pkg::DP_WRAP: begin
            // Wrap step does nothing while the cursor is inside the row.
            if (dp_op == atcw_pkg::DP_LF || wrap_needed) begin
               col_in = '0;
               if (at_bottom) begin
                  row_in     = bottom_row;
                  emit       = 1'b1;
                  emit_kind  = atcw_pkg::OP_SCROLL;
                  emit_color = bg_ff;
                  emit_last  = dp_op == atcw_pkg::DP_LF;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
         end
         atcw_pkg::DP_TAB_START: begin
            tab_left_in = TCW'(atcw_pkg::TAB_WIDTH) - TCW'(col_ff[atcw_pkg::TAB_BITS-1:0]);
            put_char_in = atcw_pkg::CHAR_SPACE;
         end
         atcw_pkg::DP_PUT_START: begin
            tab_left_in = TCW'(1);
            put_char_in = byte_ff;
         end
         atcw_pkg::DP_WRITE: begin
            emit        = 1'b1;
            emit_row    = row_ff;
            emit_col    = col_ff;
            emit_char   = put_char_ff;
            emit_color  = fg_ff;
            emit_last   = tab_left_ff == TCW'(1);
            col_in      = col_ff + COLS_W'(1);
            tab_left_in = tab_left_ff - TCW'(1);
         end
         default: ;
      endcase

      // Register writes must arrive only while idle; the block does not enforce it. Clamp the cursor to the new grid.
      if (csr_valid) begin
         case (csr_index)
            atcw_pkg::CSR_GRID_COLUMNS: begin
               cols_new = csr_data[COLS_W-1:0];
               if (cols_new == '0) begin
                  cols_new = COLS_W'(1);
               end else if (cols_new > COLS_W'(atcw_pkg::MAX_COLUMNS)) begin
                  cols_new = COLS_W'(atcw_pkg::MAX_COLUMNS);
               end
               cols_in = cols_new;
            end
            atcw_pkg::CSR_GRID_ROWS: begin
               rows_new = csr_data[ROWS_W-1:0];
               if (rows_new == '0) begin
                  rows_new = ROWS_W'(1);
               end else if (rows_new > ROWS_W'(atcw_pkg::MAX_ROWS)) begin
                  rows_new = ROWS_W'(atcw_pkg::MAX_ROWS);
               end
               rows_in = rows_new;
            end
            atcw_pkg::CSR_BACKGROUND_COLOR: bg_in = csr_data[atcw_pkg::COLOR_W-1:0];
            atcw_pkg::CSR_CONSOLE_ENABLE:   enable_in = csr_data[0];
            default: ;
         endcase
         if (ROWS_W'(row_ff) >= rows_new) begin
            row_in = ROW_W'(rows_new - ROWS_W'(1));
         end
         if (col_ff > cols_new) begin
            col_in = cols_new;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_kind_in  = out_kind_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_char_in  = out_char_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_kind_in  = emit_kind;
         out_row_in   = atcw_pkg::CELL_ROW_W'(emit_row);
         out_col_in   = atcw_pkg::CELL_COL_W'(emit_col);
         out_char_in  = emit_char;
         out_color_in = emit_color;
         out_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= atcw_pkg::MODE_NORMAL;
         for (int k = 0; k < NP; k++) begin
            params_ff[k] <= '0;
         end
         count_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         fg_ff        <= atcw_pkg::COLOR_WHITE;
         cols_ff      <= COLS_W'(80);
         rows_ff      <= ROWS_W'(25);
         bg_ff        <= atcw_pkg::COLOR_BLACK;
         enable_ff    <= 1'b1;
         tab_left_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         params_ff    <= params_in;
         count_ff     <= count_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         fg_ff        <= fg_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         bg_ff        <= bg_in;
         enable_ff    <= enable_in;
         tab_left_ff  <= tab_left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      put_char_ff  <= put_char_in;
      out_kind_ff  <= out_kind_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_char_ff  <= out_char_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_op_kind     = out_kind_ff;
   assign rsp_cell_row    = out_row_ff;
   assign rsp_cell_column = out_col_ff;
   assign rsp_cell_char   = out_char_ff;
   assign rsp_paint_color = out_color_ff;
   assign rsp_last_of_run = out_last_ff;

`ifndef ASSERT_OFF
   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!out_valid_ff || !rsp_stall))
      else $error("operation emitted over an unread beat");
   a_col_in_grid: assert property (@(posedge clock) disable iff (reset)
      col_ff <= cols_ff)
      else $error("cursor column beyond grid");
   a_row_in_grid: assert property (@(posedge clock) disable iff (reset)
      ROWS_W'(row_ff) < rows_ff)
      else $error("cursor row beyond grid");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NP))
      else $error("parameter count overflow");
`endif

endmodule

// ===== hdl/ansi_text_console_writer.sv =====
// Order: LF, BS and ESC [ 2 J emit their result beat from the decode step; a printable
// byte's cell write comes from the write step after the decode and wrap steps.
// A new byte is taken only after the last one is done (req_stall is high outside
// idle); one shared sequencer walks every byte and all operations go through one
// output register.
// Reset: parser normal, cursor home, white foreground, 80x25 grid, black background, enabled.
`timescale 1ns / 1ps

module ansi_text_console_writer (
   input  logic                                clock,
   input  logic                                reset,
   // input byte channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [atcw_pkg::BYTE_W-1:0]         req_byte_in,
   // grid operation channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_op_kind,
   output logic [atcw_pkg::CELL_ROW_W-1:0]     rsp_cell_row,
   output logic [atcw_pkg::CELL_COL_W-1:0]     rsp_cell_column,
   output logic [atcw_pkg::BYTE_W-1:0]         rsp_cell_char,
   output logic [atcw_pkg::COLOR_W-1:0]        rsp_paint_color,
   output logic                                rsp_last_of_run,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [atcw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [atcw_pkg::CSR_DATA_W-1:0]     csr_data
);

   // Controller decides one step per cycle; the datapath holds the parser,
   // cursor, grid setup and the output beat.
   atcw_pkg::dp_status_type status;
   atcw_pkg::dp_op_type     dp_op;

   atcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .dp_op     (dp_op)
   );

   // Drop, advance or emit according to the controller's step.
   atcw_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_byte_in     (req_byte_in),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .dp_op           (dp_op),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_op_kind     (rsp_op_kind),
      .rsp_cell_row    (rsp_cell_row),
      .rsp_cell_column (rsp_cell_column),
      .rsp_cell_char   (rsp_cell_char),
      .rsp_paint_color (rsp_paint_color),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== sim/tb_ansi_text_console_writer.sv =====
`timescale 1ns / 1ps

module tb_ansi_text_console_writer;
   import atcw_pkg::*;

   // Run limits and pacing.
   localparam int CYCLE_LIMIT      = 400_000;
   localparam int SETTLE_CYCLES    = 24;   // longest byte (a wrapping tab) plus margin
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int MAX_OPS_PER_BYTE = 8;

   typedef logic [BYTE_W-1:0] console_byte_type;

   // One grid operation as it leaves the block.
   typedef struct packed {
      op_kind_type             kind;
      logic [CELL_ROW_W-1:0]   row;
      logic [CELL_COL_W-1:0]   col;
      logic [BYTE_W-1:0]       ch;
      logic [COLOR_W-1:0]      color;
      logic                    last;
   } grid_op_type;

   // Console state tracker: turns accepted bytes into the grid operations they
   // must cause, keeps them in arrival order and checks what the block emits.
   class grid_op_scoreboard;
      logic [COLS_W-1:0]   columns;
      logic [ROWS_W-1:0]   rows;
      logic [COLOR_W-1:0]  background;
      logic                enabled;
      parse_mode_type      parse_mode;
      logic [PARAM_W-1:0]  params [MAX_CSI_PARAMS];
      logic [CNT_W-1:0]    param_total;
      logic [COLS_W-1:0]   cursor_col;
      logic [ROW_W-1:0]    cursor_row;
      logic [COLOR_W-1:0]  foreground;
      grid_op_type         byte_ops [$];
      grid_op_type         pending_grid_ops [$];
      int                  mismatches;

      function new();
         columns     = COLS_W'(80);
         rows        = ROWS_W'(25);
         background  = COLOR_BLACK;
         enabled     = 1'b1;
         parse_mode  = MODE_NORMAL;
         foreach (params[i]) params[i] = '0;
         param_total = '0;
         cursor_col  = '0;
         cursor_row  = '0;
         foreground  = COLOR_WHITE;
         mismatches  = 0;
      endfunction

      // Drop anything past eight operations; the state still moves on.
      function void push_op(op_kind_type kind, int row, int col, logic [BYTE_W-1:0] ch,
                            logic [COLOR_W-1:0] color);
         grid_op_type op;
         if (byte_ops.size() < MAX_OPS_PER_BYTE) begin
            op.kind  = kind;
            op.row   = row[CELL_ROW_W-1:0];
            op.col   = col[CELL_COL_W-1:0];
            op.ch    = ch;
            op.color = color;
            op.last  = 1'b0;
            byte_ops.push_back(op);
         end
      endfunction

      function void advance_line();
         cursor_col = '0;
         if (int'(cursor_row) + 1 >= int'(rows)) begin
            cursor_row = ROW_W'(rows - ROWS_W'(1));
            push_op(OP_SCROLL, 0, 0, CHAR_SPACE, background);
         end else begin
            cursor_row++;
         end
      endfunction

      // Lazy wrap: the cursor may sit one past the last column until the next cell.
      function void write_cell(logic [BYTE_W-1:0] ch);
         if (cursor_col >= columns) advance_line();
         push_op(OP_WRITE, int'(cursor_row), int'(cursor_col), ch, foreground);
         cursor_col++;
      endfunction

      function void run_csi_final(logic [BYTE_W-1:0] cmd);
         int first, second, r, c, code, i;
         first  = (param_total > 0) ? int'(params[0]) : 1;
         second = (param_total > 1) ? int'(params[P2_IDX]) : 1;
         case (cmd)
            CHAR_LOWER_M: begin
               if (param_total == 0) foreground = COLOR_WHITE;
               for (i = 0; i < int'(param_total); i++) begin
                  code = int'(params[i]);
                  if (code == 0) foreground = COLOR_WHITE;
                  else if (code >= 30 && code <= 37) foreground = NORMAL_PALETTE[code - 30];
                  else if (code >= 90 && code <= 97) foreground = BRIGHT_PALETTE[code - 90];
               end
            end
            CHAR_UPPER_J: begin
               if (first == 2) begin
                  cursor_col = '0;
                  cursor_row = '0;
                  push_op(OP_CLEAR, 0, 0, CHAR_SPACE, COLOR_BLACK);
               end
            end
            CHAR_UPPER_H: begin
               r = (first > 0) ? first - 1 : 0;
               c = (second > 0) ? second - 1 : 0;
               if (r >= int'(rows)) r = int'(rows) - 1;
               if (c >= int'(columns)) c = int'(columns) - 1;
               cursor_row = r[ROW_W-1:0];
               cursor_col = c[COLS_W-1:0];
            end
            default: ;
         endcase
      endfunction

      // Work out the operations of one accepted byte and queue them.
      function void predict_grid_ops(logic [BYTE_W-1:0] b);
         int acc, spaces, i;
         byte_ops.delete();
         if (!enabled || b == CHAR_NUL) return;
         case (parse_mode)
            MODE_CSI: begin
               if (b >= CHAR_0 && b <= CHAR_9) begin
                  if (param_total == 0) param_total = CNT_W'(1);
                  acc = int'(params[param_total - 1]) * 10 + int'(b - CHAR_0);
                  params[param_total - 1] = (acc > int'(PARAM_MAX)) ? PARAM_MAX : acc[PARAM_W-1:0];
               end else if (b == CHAR_SEMI) begin
                  if (param_total == 0) param_total = CNT_W'(1);
                  if (param_total < MAX_CSI_PARAMS) begin
                     param_total++;
                     params[param_total - 1] = '0;
                  end
               end else begin
                  run_csi_final(b);
                  parse_mode = MODE_NORMAL;
               end
            end
            MODE_ESC: begin
               if (b == CHAR_LBRACK) begin
                  parse_mode  = MODE_CSI;
                  param_total = '0;
                  params[0]   = '0;
               end else begin
                  parse_mode = MODE_NORMAL;
               end
            end
            default: begin
               case (b)
                  CHAR_ESC: parse_mode = MODE_ESC;
                  CHAR_BS: begin
                     if (cursor_col > 0) begin
                        cursor_col--;
                        push_op(OP_WRITE, int'(cursor_row), int'(cursor_col), CHAR_SPACE,
                                foreground);
                     end else if (cursor_row > 0) begin
                        cursor_row--;
                        cursor_col = columns - COLS_W'(1);
                        push_op(OP_WRITE, int'(cursor_row), int'(cursor_col), CHAR_SPACE,
                                foreground);
                     end
                  end
                  CHAR_CR:  cursor_col = '0;
                  CHAR_LF:  advance_line();
                  CHAR_TAB: begin
                     spaces = TAB_WIDTH - (int'(cursor_col) % TAB_WIDTH);
                     repeat (spaces) write_cell(CHAR_SPACE);
                  end
                  default:  write_cell(b);
               endcase
            end
         endcase
         for (i = 0; i < byte_ops.size(); i++) begin
            byte_ops[i].last = (i == byte_ops.size() - 1);
            pending_grid_ops.push_back(byte_ops[i]);
         end
      endfunction

      function void apply_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         int v;
         case (idx)
            CSR_GRID_COLUMNS: begin
               v = int'(data[8:0]);
               if (v < 1) v = 1;
               if (v > MAX_COLUMNS) v = MAX_COLUMNS;
               columns = v[COLS_W-1:0];
            end
            CSR_GRID_ROWS: begin
               v = int'(data[7:0]);
               if (v < 1) v = 1;
               if (v > MAX_ROWS) v = MAX_ROWS;
               rows = v[ROWS_W-1:0];
            end
            CSR_BACKGROUND_COLOR: background = data[COLOR_W-1:0];
            CSR_CONSOLE_ENABLE:   enabled    = data[0];
            default: ;
         endcase
         // A resize pulls the cursor back inside the grid.
         if (cursor_row >= rows) cursor_row = ROW_W'(rows - ROWS_W'(1));
         if (cursor_col > columns) cursor_col = columns;
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_grid_op(grid_op_type got);
         grid_op_type want;
         if (pending_grid_ops.size() == 0) begin
            $display("%0t: unexpected grid op, expected none actual kind %0d row %0d col %0d",
                     $time, got.kind, got.row, got.col);
            mismatches++;
            return;
         end
         want = pending_grid_ops.pop_front();
         check_field("op_kind", 32'(want.kind), 32'(got.kind));
         check_field("cell_row", 32'(want.row), 32'(got.row));
         check_field("cell_column", 32'(want.col), 32'(got.col));
         check_field("cell_char", 32'(want.ch), 32'(got.ch));
         check_field("paint_color", 32'(want.color), 32'(got.color));
         check_field("last_of_run", 32'(want.last), 32'(got.last));
      endfunction
   endclass

   // Clock, reset and every block input start at known values.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   console_byte_type req_byte_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_op_kind;
   logic [CELL_ROW_W-1:0] rsp_cell_row;
   logic [CELL_COL_W-1:0] rsp_cell_column;
   logic [BYTE_W-1:0] rsp_cell_char;
   logic [COLOR_W-1:0] rsp_paint_color;
   logic rsp_last_of_run;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_GRID_COLUMNS;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   grid_op_scoreboard sb;
   console_byte_type byte_script [$];
   grid_op_type observed_op;
   int cycle_count = 0;
   int bytes_sent = 0;     // bytes that the console acts on (NUL and disabled ones excluded)
   int burst_left = 0;
   logic long_hold_pending = 1'b0;

   // Opening bytes: text extremes, NUL, backspace at home and across a row,
   // CR, tab, LF, a bright colour, erase display, a cancelled escape and a
   // cursor move with an empty first parameter.
   localparam console_byte_type OPENING_BYTES [26] = '{
      8'h41, 8'hFF, CHAR_NUL, CHAR_BS, CHAR_CR, CHAR_BS, CHAR_TAB, CHAR_LF, CHAR_BS,
      CHAR_ESC, CHAR_LBRACK, 8'h39, 8'h37, CHAR_LOWER_M, 8'h78,
      CHAR_ESC, CHAR_LBRACK, 8'h32, CHAR_UPPER_J,
      CHAR_ESC, 8'h71,
      CHAR_ESC, CHAR_LBRACK, CHAR_SEMI, 8'h39, CHAR_UPPER_H
   };

   ansi_text_console_writer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_in     (req_byte_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_op_kind     (rsp_op_kind),
      .rsp_cell_row    (rsp_cell_row),
      .rsp_cell_column (rsp_cell_column),
      .rsp_cell_char   (rsp_cell_char),
      .rsp_paint_color (rsp_paint_color),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // Give up on a hang: the slowest correct run stays far below this.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Take every result beat the block hands over and check it in order.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         observed_op.kind  = op_kind_type'(rsp_op_kind);
         observed_op.row   = rsp_cell_row;
         observed_op.col   = rsp_cell_column;
         observed_op.ch    = rsp_cell_char;
         observed_op.color = rsp_paint_color;
         observed_op.last  = rsp_last_of_run;
         sb.check_grid_op(observed_op);
      end
   end

   // Receiver back-pressure: segments of no stall, dense and sparse random
   // stall and a fixed duty pattern. Once, on request, hold off for a long
   // stretch so the block backs up and stalls its input.
   initial begin : rsp_stall_pattern
      int seg_len, pattern, i;
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
         end
         pattern = $urandom_range(0, 3);
         seg_len = $urandom_range(5, 60);
         for (i = 0; i < seg_len; i++) begin
            @(negedge clock);
            case (pattern)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 1) == 1);
               2:       rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ((i % 7) < 3);
            endcase
         end
      end
   end

   // Offer one byte and hold it until the block takes the beat. The sender
   // works in bursts; drop valid for a random gap between them.
   task automatic send_byte(console_byte_type b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_byte_in <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (sb.enabled && b != CHAR_NUL) bytes_sent++;
      sb.predict_grid_ops(b);
   endtask

   // Stop sending and wait until every expected op is out and the block is quiet.
   task automatic wait_grid_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_grid_ops.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.apply_register(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void add_decimal(int v);
      string s;
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++) byte_script.push_back(s[i]);
   endfunction

   function automatic int pick_position();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 30);
   endfunction

   // Build one console sequence: mostly well-formed text and escapes with
   // random content, the rest noise, cancelled escapes and odd finals.
   task automatic queue_random_sequence();
      int n, i, j;
      byte_script.delete();
      case ($urandom_range(0, 11))
         0, 1, 2: begin
            n = $urandom_range(1, 8);
            repeat (n) byte_script.push_back(console_byte_type'($urandom_range(32, 255)));
         end
         3: begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               case ($urandom_range(0, 3))
                  0:       byte_script.push_back(CHAR_BS);
                  1:       byte_script.push_back(CHAR_CR);
                  2:       byte_script.push_back(CHAR_LF);
                  default: byte_script.push_back(CHAR_TAB);
               endcase
            end
         end
         4, 5: begin
            // colour select with zero to six codes
            byte_script.push_back(CHAR_ESC);
            byte_script.push_back(CHAR_LBRACK);
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++) begin
               if (i > 0) byte_script.push_back(CHAR_SEMI);
               j = $urandom_range(0, 3);
               add_decimal(j == 0 ? 0 : j == 1 ? $urandom_range(30, 37) :
                           j == 2 ? $urandom_range(90, 97) : $urandom_range(0, 120));
            end
            byte_script.push_back(CHAR_LOWER_M);
         end
         6: begin
            // cursor position, either parameter may be missing
            byte_script.push_back(CHAR_ESC);
            byte_script.push_back(CHAR_LBRACK);
            if ($urandom_range(0, 3) != 0) add_decimal(pick_position());
            if ($urandom_range(0, 3) != 0) begin
               byte_script.push_back(CHAR_SEMI);
               if ($urandom_range(0, 3) != 0) add_decimal(pick_position());
            end
            byte_script.push_back(CHAR_UPPER_H);
         end
         7: begin
            byte_script.push_back(CHAR_ESC);
            byte_script.push_back(CHAR_LBRACK);
            if ($urandom_range(0, 4) != 0)
               add_decimal(($urandom_range(0, 2) == 0) ? $urandom_range(0, 5) : 2);
            byte_script.push_back(CHAR_UPPER_J);
         end
         8: begin
            // overlong lists, saturating digit runs, stray NULs, any final
            byte_script.push_back(CHAR_ESC);
            byte_script.push_back(CHAR_LBRACK);
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) begin
               if (i > 0) byte_script.push_back(CHAR_SEMI);
               repeat ($urandom_range(0, 7))
                  byte_script.push_back(CHAR_0 + console_byte_type'($urandom_range(0, 9)));
               if ($urandom_range(0, 15) == 0) byte_script.push_back(CHAR_NUL);
            end
            case ($urandom_range(0, 4))
               0:       byte_script.push_back(CHAR_LOWER_M);
               1:       byte_script.push_back(CHAR_UPPER_H);
               2:       byte_script.push_back(CHAR_UPPER_J);
               3:       byte_script.push_back(CHAR_ESC);
               default: byte_script.push_back(console_byte_type'($urandom_range(8'h40, 8'h7E)));
            endcase
         end
         9: begin
            byte_script.push_back(CHAR_ESC);
            byte_script.push_back(console_byte_type'($urandom_range(1, 255)));
         end
         10: begin
            n = $urandom_range(1, 4);
            repeat (n) byte_script.push_back(console_byte_type'($urandom_range(0, 255)));
         end
         default: begin
            // line and tab runs to drive scrolling and wrapping
            n = $urandom_range(2, 6);
            repeat (n) byte_script.push_back(($urandom_range(0, 1) == 1) ? CHAR_LF : CHAR_TAB);
         end
      endcase
   endtask

   task automatic run_random_bytes(int target);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < target) begin
         queue_random_sequence();
         foreach (byte_script[i]) send_byte(byte_script[i]);
      end
   endtask

   initial begin : stimulus
      sb = new();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Default 80x25 grid: opening bytes, then random traffic while the
      // receiver holds off once for a long stretch.
      foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);
      long_hold_pending = 1'b1;
      run_random_bytes(65);
      wait_grid_idle();

      // Smallest grid: writes of zero clamp to one column and one row, so
      // nearly every cell wraps and scrolls; high data bits must be masked.
      write_csr(CSR_GRID_COLUMNS, 24'hFFFE00);
      write_csr(CSR_GRID_ROWS, 24'h000000);
      write_csr(CSR_BACKGROUND_COLOR, 24'($urandom_range(0, 24'hFFFFFF)));
      run_random_bytes(35);
      wait_grid_idle();

      // Largest grid: oversize writes clamp to 256 columns and 128 rows.
      write_csr(CSR_GRID_COLUMNS, 24'h0001FF);
      write_csr(CSR_GRID_ROWS, 24'h0000FF);
      write_csr(CSR_BACKGROUND_COLOR, 24'hFFFFFF);
      run_random_bytes(40);
      wait_grid_idle();

      // Disabled console drops every byte.
      write_csr(CSR_CONSOLE_ENABLE, 24'hFFFFFE);
      repeat (12) send_byte(console_byte_type'($urandom_range(0, 255)));
      wait_grid_idle();
      write_csr(CSR_CONSOLE_ENABLE, 24'h000001);

      // Small odd-sized grid for tab wrap and frequent scrolling.
      write_csr(CSR_GRID_COLUMNS, 24'($urandom_range(2, 9)));
      write_csr(CSR_GRID_ROWS, 24'($urandom_range(2, 4)));
      write_csr(CSR_BACKGROUND_COLOR, 24'($urandom_range(0, 24'hFFFFFF)));
      run_random_bytes(60);
      wait_grid_idle();

      if (sb.mismatches == 0 && sb.pending_grid_ops.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/atcw_pkg.sv
hdl/atcw_ctrl.sv
hdl/atcw_datapath.sv
hdl/ansi_text_console_writer.sv
sim/tb_ansi_text_console_writer.sv
